// ===== hdl/sadst_pkg.sv =====
// Shared types, constants and codes for the servo angle, duty and settle tracker.
// Used by every module of the block; depends on nothing else.
package sadst_pkg;

  localparam int unsigned NUM_SERVOS = 8;
  localparam int unsigned FULL_ANGLE = 90;
  localparam int unsigned SRV_IDX_W  = $clog2(NUM_SERVOS);

  localparam int unsigned CAL_W      = 10;
  localparam int unsigned CAL_LIMIT  = 1000;
  localparam int unsigned CAL_MIN_RST = 50;
  localparam int unsigned CAL_MAX_RST = 100;
  localparam int unsigned ANGLE_W    = 7;
  localparam int unsigned DUTY_W     = 17;
  localparam int unsigned DUTY_SCALE = 100;
  localparam int unsigned MOVE_W     = 10;
  localparam int unsigned MOVE_LIMIT = 1023;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SWEEP_W    = 10;
  localparam int unsigned MASK_W     = 8;

  // Reciprocal of FULL_ANGLE, rounded up; exact floor for numerators below 2^25
  localparam int unsigned RECIP_SHIFT = 31;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SHIFT) + FULL_ANGLE - 1) / FULL_ANGLE;
  localparam int unsigned RECIP_W    = $clog2(RECIP_VAL + 1);

  localparam int unsigned A100_W     = $clog2(FULL_ANGLE * DUTY_SCALE + 1);
  localparam int unsigned SPAN_NUM_W = CAL_W + A100_W;
  localparam int unsigned SPAN_PROD_W = SPAN_NUM_W + RECIP_W;
  localparam int unsigned MV_NUM_W   = ANGLE_W + SWEEP_W;
  localparam int unsigned MV_PROD_W  = MV_NUM_W + RECIP_W;
  localparam int unsigned MVQ_W      = MV_PROD_W - RECIP_SHIFT;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Command codes
  localparam logic [2:0] CMD_SET       = 3'd0;
  localparam logic [2:0] CMD_REST      = 3'd1;
  localparam logic [2:0] CMD_NUDGE     = 3'd2;
  localparam logic [2:0] CMD_CHECK_ONE = 3'd3;
  localparam logic [2:0] CMD_CHECK_ALL = 3'd4;
  localparam logic [2:0] CMD_LOAD      = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SWEEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SWEEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_REST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REAR_REST   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOVE    = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         servo_index;
    logic [ANGLE_W-1:0] target_angle;
    logic [1:0]         nudge_mode;
    logic [CAL_W-1:0]   load_min_tenths;
    logic [CAL_W-1:0]   load_max_tenths;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic               duty_updated;
    logic [2:0]         servo_out;
    logic [DUTY_W-1:0]  duty_thousandths;
    logic [MOVE_W-1:0]  move_time_ms;
    logic               arrived;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [SWEEP_W-1:0] short_sweep_ms;
    logic [SWEEP_W-1:0] long_sweep_ms;
    logic [MASK_W-1:0]  long_sweep_mask;
    logic [MASK_W-1:0]  mirrored_mask;
    logic [MASK_W-1:0]  front_group_mask;
    logic [ANGLE_W-1:0] front_rest_angle;
    logic [ANGLE_W-1:0] rear_rest_angle;
    logic [MOVE_W-1:0]  min_move_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_SCAN,
    ST_SCAN_END,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                 take_item;
    logic                 rd_en;
    logic                 rd_scan;
    logic [SRV_IDX_W-1:0] scan_idx;
    logic                 scan_init;
    logic                 scan_acc;
    logic                 mul_en;
    logic                 div_en;
    logic                 commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_math;
    logic check_all;
  } dp_stat_t;

endpackage

// ===== hdl/sadst_cfg.sv =====
// Configuration register file of the servo tracker: eight registers with reset values.
// Depends on sadst_pkg.
module sadst_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sadst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sadst_pkg::CFG_DATA_W-1:0] cfg_data,
  output sadst_pkg::cfg_t                  cfg
);
  import sadst_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHORT_SWEEP: cfg_nxt.short_sweep_ms   = cfg_data[SWEEP_W-1:0];
        CFG_LONG_SWEEP:  cfg_nxt.long_sweep_ms    = cfg_data[SWEEP_W-1:0];
        CFG_LONG_MASK:   cfg_nxt.long_sweep_mask  = cfg_data[MASK_W-1:0];
        CFG_MIRROR_MASK: cfg_nxt.mirrored_mask    = cfg_data[MASK_W-1:0];
        CFG_FRONT_MASK:  cfg_nxt.front_group_mask = cfg_data[MASK_W-1:0];
        CFG_FRONT_REST:  cfg_nxt.front_rest_angle = cfg_data[ANGLE_W-1:0];
        CFG_REAR_REST:   cfg_nxt.rear_rest_angle  = cfg_data[ANGLE_W-1:0];
        CFG_MIN_MOVE:    cfg_nxt.min_move_ms      = cfg_data[MOVE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_sweep_ms   <= SWEEP_W'(375);
      cfg_r.long_sweep_ms    <= SWEEP_W'(400);
      cfg_r.long_sweep_mask  <= MASK_W'(178);
      cfg_r.mirrored_mask    <= MASK_W'(192);
      cfg_r.front_group_mask <= MASK_W'(15);
      cfg_r.front_rest_angle <= ANGLE_W'(45);
      cfg_r.rear_rest_angle  <= ANGLE_W'(20);
      cfg_r.min_move_ms      <= MOVE_W'(100);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/sadst_ctrl.sv =====
// Controller of the servo tracker: sequences read, multiply, divide, scan and result steps.
// Depends on sadst_pkg; drives the datapath through dp_cmd_t.
module sadst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  sadst_pkg::dp_stat_t stat,
  output sadst_pkg::dp_cmd_t  cmd
);
  import sadst_pkg::*;

  state_t               state_r, state_nxt;
  logic [SRV_IDX_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    // drop the held result once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en     = 1'b1;
        cmd.scan_init = 1'b1;
        if (stat.check_all) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end else if (stat.need_math) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_SCAN: begin
        // read one deadline a cycle, fold in the one read the cycle before
        cmd.rd_en    = 1'b1;
        cmd.rd_scan  = 1'b1;
        cmd.scan_idx = scan_cnt_r;
        cmd.scan_acc = (scan_cnt_r != '0);
        if (scan_cnt_r == SRV_IDX_W'(NUM_SERVOS - 1)) begin
          state_nxt = ST_SCAN_END;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        cmd.scan_acc = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/sadst_dp.sv =====
// Datapath of the servo tracker: servo tables, duty and move-time arithmetic, result register.
// Depends on sadst_pkg; steered by sadst_ctrl through dp_cmd_t.
module sadst_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sadst_pkg::in_item_t  in_item,
  input  sadst_pkg::cfg_t      cfg,
  input  sadst_pkg::dp_cmd_t   cmd,
  output sadst_pkg::dp_stat_t  stat,
  output sadst_pkg::out_item_t out_item
);
  import sadst_pkg::*;

  // Servo tables
  logic [CAL_W-1:0]   cal_min_tbl_r  [NUM_SERVOS];
  logic [CAL_W-1:0]   cal_max_tbl_r  [NUM_SERVOS];
  logic [ANGLE_W-1:0] last_angle_tbl_r [NUM_SERVOS];
  logic [TIME_W-1:0]  deadline_tbl_r [NUM_SERVOS];

  in_item_t              item_r;
  logic [CAL_W-1:0]      lo_r, hi_r;
  logic [ANGLE_W-1:0]    last_r;
  logic [TIME_W-1:0]     dl_r;
  logic [A100_W-1:0]     a100_r;
  logic                  acc_r;
  logic [SPAN_NUM_W-1:0] span_num_r;
  logic                  neg_r;
  logic [MV_NUM_W-1:0]   mv_num_r;
  logic [DUTY_W-1:0]     span_r;
  logic [MVQ_W-1:0]      mvq_r;
  out_item_t             out_r;

  logic [SRV_IDX_W-1:0]   idx;
  logic [SRV_IDX_W-1:0]   rd_addr;
  logic                   bad_cmd;
  logic                   range_bad;
  logic                   mirrored;
  logic [ANGLE_W-1:0]     rest_sel, rest_ang, cmd_ang, eff_ang;
  logic [A100_W-1:0]      a100;
  logic [CAL_W-1:0]       cal_diff;
  logic [ANGLE_W-1:0]     ang_diff;
  logic [SWEEP_W-1:0]     sweep;
  logic [SPAN_PROD_W-1:0] span_prod;
  logic [MV_PROD_W-1:0]   mv_prod;
  logic [DUTY_W:0]        lo100, duty_sum;
  logic [MVQ_W-1:0]       mv_floor;
  logic [MOVE_W-1:0]      mv;
  logic                   nudge_up, nudge_max;
  logic [CAL_W-1:0]       nudge_src, nudge_val;
  logic [CAL_W-1:0]       load_min, load_max;
  logic                   wr_last, wr_dl, wr_min, wr_max;
  logic [ANGLE_W-1:0]     last_val;
  logic [CAL_W-1:0]       min_val, max_val;
  out_item_t              out_nxt;

  assign out_item = out_r;

  assign idx       = item_r.servo_index[SRV_IDX_W-1:0];
  assign rd_addr   = cmd.rd_scan ? cmd.scan_idx : idx;
  assign bad_cmd   = (item_r.command > CMD_LOAD) ||
                     ({1'b0, item_r.servo_index} >= 4'(NUM_SERVOS));
  assign range_bad = item_r.target_angle > ANGLE_W'(FULL_ANGLE);
  assign mirrored  = cfg.mirrored_mask[idx];

  assign stat.check_all = (item_r.command == CMD_CHECK_ALL);
  assign stat.need_math = !bad_cmd &&
                          (((item_r.command == CMD_SET) && !range_bad) ||
                           (item_r.command == CMD_REST));

  // Effective angle for the duty, mirrored where the mask says so
  always_comb begin
    rest_sel = cfg.front_group_mask[idx] ? cfg.front_rest_angle : cfg.rear_rest_angle;
    rest_ang = (rest_sel > ANGLE_W'(FULL_ANGLE)) ? ANGLE_W'(FULL_ANGLE) : rest_sel;
    cmd_ang  = (item_r.command == CMD_REST) ? rest_ang : item_r.target_angle;
    eff_ang  = mirrored ? ANGLE_W'(FULL_ANGLE) - cmd_ang : cmd_ang;
    a100     = A100_W'(eff_ang) * A100_W'(DUTY_SCALE);
  end

  // Operands of the first multiply
  always_comb begin
    cal_diff = (hi_r >= lo_r) ? hi_r - lo_r : lo_r - hi_r;
    ang_diff = (item_r.target_angle > last_r) ? item_r.target_angle - last_r
                                              : last_r - item_r.target_angle;
    sweep    = cfg.long_sweep_mask[idx] ? cfg.long_sweep_ms : cfg.short_sweep_ms;
  end

  // Divide by the full angle through the rounded-up reciprocal
  assign span_prod = SPAN_PROD_W'(span_num_r) * SPAN_PROD_W'(RECIP_VAL);
  assign mv_prod   = MV_PROD_W'(mv_num_r) * MV_PROD_W'(RECIP_VAL);

  // Final duty and move time
  always_comb begin
    lo100    = (DUTY_W + 1)'(lo_r) * (DUTY_W + 1)'(DUTY_SCALE);
    duty_sum = neg_r ? lo100 - (DUTY_W + 1)'(span_r) : lo100 + (DUTY_W + 1)'(span_r);
    mv_floor = (mvq_r < MVQ_W'(cfg.min_move_ms)) ? MVQ_W'(cfg.min_move_ms) : mvq_r;
    mv       = (mv_floor > MVQ_W'(MOVE_LIMIT)) ? MOVE_W'(MOVE_LIMIT)
                                                : mv_floor[MOVE_W-1:0];
  end

  // Nudge and load values
  always_comb begin
    nudge_up  = item_r.nudge_mode[0] ^ mirrored;
    nudge_max = item_r.nudge_mode[1] ^ mirrored;
    nudge_src = nudge_max ? hi_r : lo_r;
    if (nudge_up) begin
      nudge_val = (nudge_src >= CAL_W'(CAL_LIMIT)) ? CAL_W'(CAL_LIMIT) : nudge_src + 1'b1;
    end else begin
      nudge_val = (nudge_src == '0) ? '0 : nudge_src - 1'b1;
    end
    load_min = (item_r.load_min_tenths > CAL_W'(CAL_LIMIT)) ? CAL_W'(CAL_LIMIT)
                                                            : item_r.load_min_tenths;
    load_max = (item_r.load_max_tenths > CAL_W'(CAL_LIMIT)) ? CAL_W'(CAL_LIMIT)
                                                            : item_r.load_max_tenths;
  end

  // Result and table updates
  always_comb begin
    out_nxt                  = '0;
    out_nxt.servo_out        = item_r.servo_index;
    out_nxt.status           = STAT_OK;
    wr_last                  = 1'b0;
    wr_dl                    = 1'b0;
    wr_min                   = 1'b0;
    wr_max                   = 1'b0;
    last_val                 = item_r.target_angle;
    min_val                  = nudge_val;
    max_val                  = nudge_val;
    if (item_r.command == CMD_CHECK_ALL) begin
      out_nxt.servo_out = '0;
      out_nxt.arrived   = acc_r;
    end else if (bad_cmd) begin
      out_nxt.status = STAT_BAD;
    end else begin
      case (item_r.command)
        CMD_SET: begin
          if (range_bad) begin
            out_nxt.status = STAT_RANGE;
          end else begin
            out_nxt.duty_updated     = 1'b1;
            out_nxt.duty_thousandths = duty_sum[DUTY_W-1:0];
            out_nxt.move_time_ms     = mv;
            wr_last                  = (last_r != item_r.target_angle);
            wr_dl                    = (last_r != item_r.target_angle);
          end
        end
        CMD_REST: begin
          out_nxt.duty_updated     = 1'b1;
          out_nxt.duty_thousandths = duty_sum[DUTY_W-1:0];
          wr_last                  = 1'b1;
          last_val                 = '0;
        end
        CMD_NUDGE: begin
          wr_max = nudge_max;
          wr_min = !nudge_max;
        end
        CMD_CHECK_ONE: begin
          out_nxt.arrived = (dl_r < item_r.now_ms);
        end
        CMD_LOAD: begin
          wr_min  = 1'b1;
          wr_max  = 1'b1;
          min_val = load_min;
          max_val = load_max;
        end
        default: out_nxt.status = STAT_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        cal_min_tbl_r[i]    <= CAL_W'(CAL_MIN_RST);
        cal_max_tbl_r[i]    <= CAL_W'(CAL_MAX_RST);
        last_angle_tbl_r[i] <= '0;
        deadline_tbl_r[i]   <= '0;
      end
    end else if (cmd.commit) begin
      if (wr_min) begin
        cal_min_tbl_r[idx] <= min_val;
      end
      if (wr_max) begin
        cal_max_tbl_r[idx] <= max_val;
      end
      if (wr_last) begin
        last_angle_tbl_r[idx] <= last_val;
      end
      if (wr_dl) begin
        deadline_tbl_r[idx] <= item_r.now_ms + TIME_W'(mv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b1;
    end else if (cmd.scan_init) begin
      acc_r <= 1'b1;
    end else if (cmd.scan_acc) begin
      acc_r <= acc_r & (dl_r < item_r.now_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_item;
    end
    if (cmd.rd_en) begin
      lo_r   <= cal_min_tbl_r[rd_addr];
      hi_r   <= cal_max_tbl_r[rd_addr];
      last_r <= last_angle_tbl_r[rd_addr];
      dl_r   <= deadline_tbl_r[rd_addr];
      a100_r <= a100;
    end
    if (cmd.mul_en) begin
      span_num_r <= SPAN_NUM_W'(cal_diff) * SPAN_NUM_W'(a100_r);
      neg_r      <= (hi_r < lo_r);
      mv_num_r   <= MV_NUM_W'(ang_diff) * MV_NUM_W'(sweep);
    end
    if (cmd.div_en) begin
      span_r <= span_prod[RECIP_SHIFT +: DUTY_W];
      mvq_r  <= mv_prod[MV_PROD_W-1:RECIP_SHIFT];
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/servo_angle_duty_and_settle_tracker_unit.sv =====
// Top level of the servo angle, duty and settle tracker.
// Depends on sadst_pkg, sadst_cfg, sadst_ctrl and sadst_dp.

// The block keeps calibration, last angle and settle deadline for eight servos and
// handles one command item at a time. A set-angle or rest item passes through the
// table read, one multiply for the duty span and the move distance, one reciprocal
// multiply that divides both by the full angle, then the result step; nudge, load,
// check-one and rejected items go from the table read to the result step; check-all
// reads the eight deadlines one per cycle through a single table port before the
// result step. Results leave through an output register, so a new item is taken
// while the previous result still waits; the next result is held back until that
// register is free. Configuration writes are taken on every cycle and must only
// happen while the block is idle.
module servo_angle_duty_and_settle_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sadst_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sadst_pkg::out_item_t             out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sadst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sadst_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sadst_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  sadst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sadst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  sadst_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_data),
    .cfg      (cfg),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_item (out_data)
  );

  // One item in flight: after an accept the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is still in work");

  // No result can appear in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early after accept");

  // Rejected items drive no duty and no move time
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      !out_data.duty_updated && (out_data.move_time_ms == '0))
    else $error("rejected item carries a duty or move time");

  // A driven duty never reports a check result
  a_duty_no_arrive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_updated |-> !out_data.arrived)
    else $error("duty update flagged as arrived");

endmodule

// ===== sim/servo_angle_duty_and_settle_tracker_unit_tb.sv =====
// Self-checking testbench for the servo angle, duty and settle tracker top level.
// Needs sadst_pkg and the RTL under hdl; predicts every result item in SystemVerilog
// and compares it field by field under random idling, back-pressure and register settings.
module servo_angle_duty_and_settle_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sadst_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  servo_angle_duty_and_settle_tracker_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted servo table and register settings
  cfg_t        tracker_cfg;
  bit [10:0]   cal_min_tbl [NUM_SERVOS];
  bit [10:0]   cal_max_tbl [NUM_SERVOS];
  bit [6:0]    last_angle_tbl [NUM_SERVOS];
  bit [31:0]   deadline_tbl [NUM_SERVOS];

  out_item_t   servo_reports_due [$];
  int unsigned mismatches = 0;
  int unsigned cmd_seen [8];
  int unsigned reg_writes = 0;
  int unsigned results_seen = 0;

  // Traffic shaping
  bit          sender_idles = 1'b1;
  int unsigned stall_pct = 30;
  int unsigned stall_run = 0;
  int unsigned hold_left = 0;
  bit [31:0]   clock_ms = 32'd0;

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("ERROR %0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [DUTY_W-1:0] duty_for(int unsigned idx, int unsigned angle);
    int unsigned a;
    longint lo, hi, aa, full, span, total;
    a = tracker_cfg.mirrored_mask[idx] ? FULL_ANGLE - angle : angle;
    lo = cal_min_tbl[idx];
    hi = cal_max_tbl[idx];
    aa = a;
    full = FULL_ANGLE;
    // signed span: an inverted calibration truncates toward zero
    span = (hi - lo) * 100 * aa / full;
    total = lo * 100 + span;
    return total[DUTY_W-1:0];
  endfunction

  function automatic bit [10:0] nudged(bit [10:0] v, bit up);
    if (up)
      return (v >= CAL_LIMIT) ? 11'(CAL_LIMIT) : v + 11'd1;
    return (v == 0) ? 11'd0 : v - 11'd1;
  endfunction

  function automatic out_item_t track_servo_command(in_item_t it);
    out_item_t   r;
    int unsigned idx, ang, last, diff, sweep, rest, mv, i;
    bit          up, on_max, all_done;
    r = '0;
    idx = it.servo_index;
    r.servo_out = it.servo_index;
    r.status = STAT_OK;
    case (it.command)
      CMD_CHECK_ALL: begin
        r.servo_out = '0;
        all_done = 1'b1;
        for (i = 0; i < NUM_SERVOS; i++)
          if (!(deadline_tbl[i] < it.now_ms)) all_done = 1'b0;
        r.arrived = all_done;
      end
      CMD_SET: begin
        if (it.target_angle > FULL_ANGLE) begin
          r.status = STAT_RANGE;
        end else begin
          ang = it.target_angle;
          last = last_angle_tbl[idx];
          diff = (ang > last) ? ang - last : last - ang;
          sweep = tracker_cfg.long_sweep_mask[idx] ? tracker_cfg.long_sweep_ms
                                                   : tracker_cfg.short_sweep_ms;
          r.duty_thousandths = duty_for(idx, ang);
          r.duty_updated = 1'b1;
          mv = diff * sweep / FULL_ANGLE;
          if (mv < tracker_cfg.min_move_ms) mv = tracker_cfg.min_move_ms;
          if (mv > MOVE_LIMIT) mv = MOVE_LIMIT;
          r.move_time_ms = mv;
          // hold deadline when the angle did not change
          if (last != ang) begin
            last_angle_tbl[idx] = ang;
            deadline_tbl[idx] = it.now_ms + mv;
          end
        end
      end
      CMD_REST: begin
        rest = tracker_cfg.front_group_mask[idx] ? tracker_cfg.front_rest_angle
                                                 : tracker_cfg.rear_rest_angle;
        if (rest > FULL_ANGLE) rest = FULL_ANGLE;
        r.duty_thousandths = duty_for(idx, rest);
        r.duty_updated = 1'b1;
        last_angle_tbl[idx] = '0;
      end
      CMD_NUDGE: begin
        up = it.nudge_mode[0];
        on_max = it.nudge_mode[1];
        if (tracker_cfg.mirrored_mask[idx]) begin
          up = !up;
          on_max = !on_max;
        end
        if (on_max)
          cal_max_tbl[idx] = nudged(cal_max_tbl[idx], up);
        else
          cal_min_tbl[idx] = nudged(cal_min_tbl[idx], up);
      end
      CMD_CHECK_ONE: begin
        r.arrived = deadline_tbl[idx] < it.now_ms;
      end
      CMD_LOAD: begin
        cal_min_tbl[idx] = (it.load_min_tenths > CAL_LIMIT) ? 11'(CAL_LIMIT)
                                                            : 11'(it.load_min_tenths);
        cal_max_tbl[idx] = (it.load_max_tenths > CAL_LIMIT) ? 11'(CAL_LIMIT)
                                                            : 11'(it.load_max_tenths);
      end
      default: begin
        r.status = STAT_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic void reset_prediction();
    int unsigned i;
    tracker_cfg.short_sweep_ms   = 10'd375;
    tracker_cfg.long_sweep_ms    = 10'd400;
    tracker_cfg.long_sweep_mask  = 8'd178;
    tracker_cfg.mirrored_mask    = 8'd192;
    tracker_cfg.front_group_mask = 8'd15;
    tracker_cfg.front_rest_angle = 7'd45;
    tracker_cfg.rear_rest_angle  = 7'd20;
    tracker_cfg.min_move_ms      = 10'd100;
    for (i = 0; i < NUM_SERVOS; i++) begin
      cal_min_tbl[i] = CAL_MIN_RST;
      cal_max_tbl[i] = CAL_MAX_RST;
      last_angle_tbl[i] = '0;
      deadline_tbl[i] = '0;
    end
  endfunction

  function automatic in_item_t make_item(logic [2:0] cmd, int unsigned idx, int unsigned angle,
                                         int unsigned mode, int unsigned lmin,
                                         int unsigned lmax, bit [31:0] now);
    in_item_t it;
    it.command = cmd;
    it.servo_index = idx;
    it.target_angle = angle;
    it.nudge_mode = mode;
    it.load_min_tenths = lmin;
    it.load_max_tenths = lmax;
    it.now_ms = now;
    return it;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned cal_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, CAL_LIMIT);
    if (r < 78) return $urandom_range(0, 2);
    if (r < 86) return $urandom_range(998, 1023);
    return $urandom_range(0, 1023);
  endfunction

  function automatic in_item_t random_command();
    in_item_t    it;
    int unsigned r;
    it.servo_index = $urandom_range(0, NUM_SERVOS - 1);
    it.nudge_mode = $urandom_range(0, 3);
    it.load_min_tenths = cal_value();
    it.load_max_tenths = cal_value();
    r = $urandom_range(0, 99);
    if (r < 10)
      it.target_angle = last_angle_tbl[it.servo_index];
    else if (r < 88)
      it.target_angle = $urandom_range(0, FULL_ANGLE);
    else
      it.target_angle = $urandom_range(FULL_ANGLE + 1, 127);
    // advance time so deadlines are sometimes passed, sometimes not
    if ($urandom_range(0, 99) < 3)
      clock_ms = $urandom();
    else
      clock_ms = clock_ms + $urandom_range(0, 250);
    it.now_ms = clock_ms;
    r = $urandom_range(0, 99);
    if (r < 34)      it.command = CMD_SET;
    else if (r < 44) it.command = CMD_REST;
    else if (r < 56) it.command = CMD_NUDGE;
    else if (r < 70) it.command = CMD_CHECK_ONE;
    else if (r < 80) it.command = CMD_CHECK_ALL;
    else if (r < 93) it.command = CMD_LOAD;
    else             it.command = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
    return it;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.short_sweep_ms   = $urandom_range(0, 1023);
    c.long_sweep_ms    = $urandom_range(0, 1023);
    c.long_sweep_mask  = $urandom_range(0, 255);
    c.mirrored_mask    = $urandom_range(0, 255);
    c.front_group_mask = $urandom_range(0, 255);
    c.front_rest_angle = $urandom_range(0, 127);
    c.rear_rest_angle  = $urandom_range(0, FULL_ANGLE);
    c.min_move_ms      = $urandom_range(0, 300);
    return c;
  endfunction

  // Offer one item; valid stays high after acceptance until the next call or stop_sending
  task automatic push_item(in_item_t it);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    servo_reports_due.push_back(track_servo_command(it));
    cmd_seen[it.command]++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (servo_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_SHORT_SWEEP: tracker_cfg.short_sweep_ms   = val;
      CFG_LONG_SWEEP:  tracker_cfg.long_sweep_ms    = val;
      CFG_LONG_MASK:   tracker_cfg.long_sweep_mask  = val[MASK_W-1:0];
      CFG_MIRROR_MASK: tracker_cfg.mirrored_mask    = val[MASK_W-1:0];
      CFG_FRONT_MASK:  tracker_cfg.front_group_mask = val[MASK_W-1:0];
      CFG_FRONT_REST:  tracker_cfg.front_rest_angle = val[ANGLE_W-1:0];
      CFG_REAR_REST:   tracker_cfg.rear_rest_angle  = val[ANGLE_W-1:0];
      default:         tracker_cfg.min_move_ms      = val;
    endcase
  endtask

  // Only while idle: drop input traffic and wait for every result first
  task automatic apply_settings(cfg_t c);
    stop_sending();
    wait_drained();
    write_setting(CFG_SHORT_SWEEP, c.short_sweep_ms);
    write_setting(CFG_LONG_SWEEP, c.long_sweep_ms);
    write_setting(CFG_LONG_MASK, CFG_DATA_W'(c.long_sweep_mask));
    write_setting(CFG_MIRROR_MASK, CFG_DATA_W'(c.mirrored_mask));
    write_setting(CFG_FRONT_MASK, CFG_DATA_W'(c.front_group_mask));
    write_setting(CFG_FRONT_REST, CFG_DATA_W'(c.front_rest_angle));
    write_setting(CFG_REAR_REST, CFG_DATA_W'(c.rear_rest_angle));
    write_setting(CFG_MIN_MOVE, c.min_move_ms);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_items(int unsigned count);
    int unsigned n;
    for (n = 0; n < count; n++) begin
      // every hundred items pick either random idling or a busy stretch
      if (n % 100 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          sender_idles = 1'b0;
          stall_pct = 0;
        end else begin
          sender_idles = 1'b1;
          stall_pct = $urandom_range(10, 50);
        end
      end
      push_item(random_command());
    end
    stop_sending();
    sender_idles = 1'b1;
    stall_pct = 30;
  endtask

  task automatic test_directed_cases();
    push_item(make_item(CMD_SET, 0, 90, 0, 0, 0, 32'd1000));
    push_item(make_item(CMD_SET, 0, 90, 0, 0, 0, 32'd2000));
    push_item(make_item(CMD_SET, 7, 45, 0, 0, 0, 32'hFFFF_FF00));
    push_item(make_item(CMD_SET, 6, 0, 0, 0, 0, 32'd50));
    push_item(make_item(CMD_SET, 2, 91, 0, 0, 0, 32'd60));
    push_item(make_item(CMD_SET, 3, 127, 3, 1023, 1023, 32'd70));
    push_item(make_item(CMD_SET, 1, 1, 0, 0, 0, 32'd80));
    push_item(make_item(CMD_REST, 0, 0, 0, 0, 0, 32'd90));
    push_item(make_item(CMD_REST, 5, 0, 0, 0, 0, 32'd100));
    push_item(make_item(CMD_REST, 7, 0, 0, 0, 0, 32'd110));
    push_item(make_item(CMD_LOAD, 2, 0, 0, 0, 1023, 32'd120));
    push_item(make_item(CMD_NUDGE, 2, 0, 0, 0, 0, 32'd130));
    push_item(make_item(CMD_NUDGE, 2, 0, 3, 0, 0, 32'd140));
    push_item(make_item(CMD_NUDGE, 2, 0, 1, 0, 0, 32'd150));
    push_item(make_item(CMD_NUDGE, 2, 0, 2, 0, 0, 32'd160));
    push_item(make_item(CMD_NUDGE, 6, 0, 0, 0, 0, 32'd170));
    push_item(make_item(CMD_NUDGE, 6, 0, 3, 0, 0, 32'd180));
    push_item(make_item(CMD_LOAD, 4, 0, 0, 1000, 0, 32'd190));
    push_item(make_item(CMD_SET, 4, 60, 0, 0, 0, 32'd200));
    push_item(make_item(CMD_CHECK_ONE, 0, 0, 0, 0, 0, 32'd0));
    push_item(make_item(CMD_CHECK_ONE, 7, 0, 0, 0, 0, 32'hFFFF_FFFF));
    push_item(make_item(CMD_CHECK_ALL, 3, 0, 0, 0, 0, 32'd0));
    push_item(make_item(CMD_CHECK_ALL, 5, 0, 0, 0, 0, 32'hFFFF_FFFF));
    push_item(make_item(CMD_SPARE_A, 3, 30, 1, 5, 5, 32'd210));
    push_item(make_item(CMD_SPARE_B, 3, 30, 2, 5, 5, 32'd220));
    stop_sending();
  endtask

  task automatic test_random_traffic();
    run_random_items(300);
  endtask

  task automatic test_setting_extremes();
    cfg_t c;
    c = '0;
    apply_settings(c);
    run_random_items(200);
    c.short_sweep_ms   = 10'd1023;
    c.long_sweep_ms    = 10'd1023;
    c.long_sweep_mask  = 8'hFF;
    c.mirrored_mask    = 8'hFF;
    c.front_group_mask = 8'hFF;
    c.front_rest_angle = 7'd127;
    c.rear_rest_angle  = 7'd90;
    c.min_move_ms      = 10'd1023;
    apply_settings(c);
    run_random_items(200);
  endtask

  task automatic test_random_settings();
    int unsigned p;
    for (p = 0; p < 3; p++) begin
      apply_settings(random_settings());
      run_random_items(200);
    end
  endtask

  // Block the result side for a long stretch while items keep coming
  task automatic test_output_hold();
    int unsigned n;
    wait_drained();
    sender_idles = 1'b0;
    hold_left = 250;
    for (n = 0; n < 40; n++) push_item(random_command());
    stop_sending();
    sender_idles = 1'b1;
  endtask

  task automatic test_paused_sender();
    run_random_items(60);
    wait_drained();
    run_random_items(60);
  endtask

  // Result side: random stall runs, or a counted long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 30);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (servo_reports_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_data, 0);
      end else begin
        want = servo_reports_due.pop_front();
        if (out_data.duty_updated !== want.duty_updated)
          report_mismatch("duty_updated", out_data.duty_updated, want.duty_updated);
        if (out_data.servo_out !== want.servo_out)
          report_mismatch("servo_out", out_data.servo_out, want.servo_out);
        if (out_data.duty_thousandths !== want.duty_thousandths)
          report_mismatch("duty_thousandths", out_data.duty_thousandths,
                          want.duty_thousandths);
        if (out_data.move_time_ms !== want.move_time_ms)
          report_mismatch("move_time_ms", out_data.move_time_ms, want.move_time_ms);
        if (out_data.arrived !== want.arrived)
          report_mismatch("arrived", out_data.arrived, want.arrived);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", servo_reports_due.size());
    $display("servo_angle_duty_and_settle_tracker_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned waited;
    reset_prediction();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic();
    test_setting_extremes();
    test_random_settings();
    test_output_hold();
    test_paused_sender();
    stop_sending();
    waited = 0;
    while (servo_reports_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (servo_reports_due.size() != 0)
      report_mismatch("results never delivered", servo_reports_due.size(), 0);
    repeat (20) @(posedge clk);
    $display("covered %0d items: set %0d, rest %0d, nudge %0d, check one %0d, check all %0d,",
             cmd_seen.sum(), cmd_seen[CMD_SET], cmd_seen[CMD_REST], cmd_seen[CMD_NUDGE],
             cmd_seen[CMD_CHECK_ONE], cmd_seen[CMD_CHECK_ALL]);
    $display("load %0d, invalid %0d; %0d register writes, %0d results checked",
             cmd_seen[CMD_LOAD], cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B],
             reg_writes, results_seen);
    if (mismatches == 0)
      $display("servo_angle_duty_and_settle_tracker_unit: match");
    else
      $display("servo_angle_duty_and_settle_tracker_unit: mismatch");
    $finish;
  end

endmodule
